### sv/hct_pkg.sv
// Shared types, register indexes and drive tables of the hall commutation tracker.
// Used by hall_commutation_tracker; depends on nothing else.
package hct_pkg;

   // Configuration register indexes.
   localparam logic CSR_ERROR_LIMIT = 1'b0;
   localparam logic CSR_PERIOD_CAP  = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [7:0]  ERROR_LIMIT_RESET = 8'd20;
   localparam logic [13:0] PERIOD_CAP_RESET  = 14'd10000;

   // Hall codes that matter for validity, reference crossings and direction.
   localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
   localparam logic [2:0] HALL_ALL_HIGH = 3'd7;
   localparam logic [2:0] HALL_REF_LOW  = 3'd1;
   localparam logic [2:0] HALL_REF_HIGH = 3'd6;
   localparam logic [2:0] HALL_CODE_2   = 3'd2;
   localparam logic [2:0] HALL_CODE_3   = 3'd3;
   localparam logic [2:0] HALL_CODE_4   = 3'd4;
   localparam logic [2:0] HALL_CODE_5   = 3'd5;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   // Phase selection of one bridge side.
   typedef enum logic [1:0] {
      PHASE_NONE = 2'd0,
      PHASE_U    = 2'd1,
      PHASE_V    = 2'd2,
      PHASE_W    = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type high_phase;
      phase_type low_phase;
   } drive_type;

   localparam drive_type DRIVE_OFF = '{high_phase: PHASE_NONE, low_phase: PHASE_NONE};

   // Six-step drive for a hall code; invalid codes give all phases off.
   function automatic drive_type drive_lookup(input logic [2:0] code, input logic ccw);
      drive_type d;
      d = DRIVE_OFF;
      unique case (code)
         HALL_REF_LOW:  d = ccw ? '{PHASE_V, PHASE_W} : '{PHASE_W, PHASE_V};
         HALL_CODE_2:   d = ccw ? '{PHASE_U, PHASE_V} : '{PHASE_V, PHASE_U};
         HALL_CODE_3:   d = ccw ? '{PHASE_U, PHASE_W} : '{PHASE_W, PHASE_U};
         HALL_CODE_4:   d = ccw ? '{PHASE_W, PHASE_U} : '{PHASE_U, PHASE_W};
         HALL_CODE_5:   d = ccw ? '{PHASE_V, PHASE_U} : '{PHASE_U, PHASE_V};
         HALL_REF_HIGH: d = ccw ? '{PHASE_W, PHASE_V} : '{PHASE_V, PHASE_W};
         default:       d = DRIVE_OFF;
      endcase
      return d;
   endfunction

endpackage

### sv/hall_commutation_tracker.sv
// Hall commutation tracker: hall validity, half-revolution period, direction
// and six-step drive selection for one motor. Depends on hct_pkg.
//
// Usage:
//   req channel: one transfer per PWM tick. req_tdata carries hall_code,
//   run_request and want_ccw.
//   rsp channel: exactly one transfer per accepted tick, carrying the drive
//   phases, the sticky hall fault, the latest period and the measured
//   direction, all as they stand after that tick.
//   csr channel: register writes (0 error_limit, 1 period_cap), always ready.
//   Write only while no tick is in flight.
// Timing:
//   The result shows in the cycle after the tick is accepted. One tick per
//   cycle is sustained while results are taken; the tracker state and the
//   result register both update at the accepting edge by a single combinational pass.
// Reset:
//   Synchronous, active high. Clears all tracking state, loads the register
//   defaults and empties the result register.
// Stall:
//   While a result waits with rsp_tready low, req_tready is low; as soon as
//   the waiting result is taken a new tick can enter in the same cycle.
module hall_commutation_tracker
   import hct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input ticks.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] hall_code, [3] run_request, [4] want_ccw, rest 0
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] high_phase, [3:2] low_phase, [4] hall_fault,
                                    // [18:5] period_ticks, [19] measured_ccw, rest 0
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [13:0] csr_data
);

   // Configuration registers.
   logic [7:0]  error_limit_ff;
   logic [13:0] period_cap_ff;

   // Tracking state.
   logic [7:0]  invalid_count_ff, invalid_count_in;
   logic        fault_ff, fault_in;
   logic [13:0] tick_count_ff, tick_count_in;
   logic [13:0] period_ff, period_in;
   logic [2:0]  previous_code_ff, previous_code_in;
   logic [2:0]  reference_code_ff, reference_code_in;
   logic        direction_ff, direction_in;
   drive_type   drive_ff, drive_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic [2:0]  hall_code;
   logic        run_request;
   logic        want_ccw;
   logic        code_valid;
   logic        req_accept;

   assign hall_code   = req_tdata[2:0];
   assign run_request = req_tdata[3];
   assign want_ccw    = req_tdata[4];
   assign code_valid  = (hall_code != HALL_ALL_LOW) && (hall_code != HALL_ALL_HIGH);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff <= ERROR_LIMIT_RESET;
         period_cap_ff  <= PERIOD_CAP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ERROR_LIMIT: error_limit_ff <= csr_data[7:0];
            CSR_PERIOD_CAP:  period_cap_ff  <= csr_data;
            default:         error_limit_ff <= error_limit_ff;
         endcase
      end
   end

   // Next tracking state for the tick on the input.
   always_comb begin
      invalid_count_in  = invalid_count_ff;
      fault_in          = fault_ff;
      tick_count_in     = tick_count_ff;
      period_in         = period_ff;
      previous_code_in  = previous_code_ff;
      reference_code_in = reference_code_ff;
      direction_in      = direction_ff;
      drive_in          = drive_ff;

      // Hall validity and sticky fault.
      if (!code_valid) begin
         if (invalid_count_ff != COUNT_MAX) begin
            invalid_count_in = invalid_count_ff + 8'd1;
         end
         if (invalid_count_in > error_limit_ff) begin
            fault_in = 1'b1;
         end
      end else begin
         invalid_count_in = '0;
      end

      // Tick counter saturates at the cap, which then stands as the period.
      if (tick_count_ff < period_cap_ff) begin
         tick_count_in = tick_count_ff + 14'd1;
      end else begin
         period_in = tick_count_ff;
      end

      // A change onto the reference code closes a half revolution.
      if (previous_code_ff != hall_code) begin
         if (hall_code == reference_code_ff) begin
            period_in     = tick_count_in;
            tick_count_in = '0;
            if (reference_code_ff == HALL_REF_LOW) begin
               reference_code_in = HALL_REF_HIGH;
               if (previous_code_ff == HALL_CODE_3) begin
                  direction_in = 1'b1;
               end else if (previous_code_ff == HALL_CODE_5) begin
                  direction_in = 1'b0;
               end
            end else begin
               reference_code_in = HALL_REF_LOW;
               if (previous_code_ff == HALL_CODE_4) begin
                  direction_in = 1'b1;
               end else if (previous_code_ff == HALL_CODE_2) begin
                  direction_in = 1'b0;
               end
            end
         end
         previous_code_in = hall_code;
      end

      // Drive selection; an invalid code keeps the last drive.
      if (!run_request || fault_in) begin
         drive_in = DRIVE_OFF;
      end else if (code_valid) begin
         drive_in = drive_lookup(hall_code, want_ccw);
      end

      rsp_data_in = {4'd0, direction_in, period_in, fault_in,
                     drive_in.low_phase, drive_in.high_phase};
   end

   // Tracking state advances on each accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_count_ff  <= '0;
         fault_ff          <= 1'b0;
         tick_count_ff     <= '0;
         period_ff         <= '0;
         previous_code_ff  <= HALL_ALL_LOW;
         reference_code_ff <= HALL_REF_LOW;
         direction_ff      <= 1'b0;
         drive_ff          <= DRIVE_OFF;
      end else if (req_accept) begin
         invalid_count_ff  <= invalid_count_in;
         fault_ff          <= fault_in;
         tick_count_ff     <= tick_count_in;
         period_ff         <= period_in;
         previous_code_ff  <= previous_code_in;
         reference_code_ff <= reference_code_in;
         direction_ff      <= direction_in;
         drive_ff          <= drive_in;
      end
   end

   // Result register: loads on an accepted tick, empties on a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/hct_checker.sv
// Port-level checks of the hall commutation tracker and their binding.
// Depends on hall_commutation_tracker; sees its ports only.
module hct_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A held result keeps its contents until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Every accepted tick shows a result in the next cycle.
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   // The hall fault never clears once a result has shown it.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |=> !rsp_tvalid || rsp_tdata[4])
      else $error("hall fault cleared without reset");

   // A faulted result drives no phase.
   a_fault_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3:0] == 4'd0)
      else $error("drive active during hall fault");

   // The same phase is never switched high and low together.
   a_no_shoot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != rsp_tdata[3:2]) || (rsp_tdata[3:0] == 4'd0))
      else $error("phase driven high and low at once");

endmodule

bind hall_commutation_tracker hct_port_checks u_hct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
